FILE: design/psps_pkg.sv
// psps_pkg: shared widths, register indexes and bundle types for the
// three-light photometric stereo pixel solver
// no dependencies
`default_nettype none
package psps_pkg;

  localparam int ROW_BITS = 12;
  localparam int COL_BITS = 12;
  localparam int IW       = 8;
  localparam int LIGHT_W  = 60;
  localparam int LW       = 20;
  localparam int AW       = 2 * LW + 1;
  localparam int DW       = 3 * LW + 2;
  localparam int NW       = AW + IW + 2;
  localparam int VW       = NW - 1;
  localparam int SW       = 30;
  localparam int SHW      = 5;
  localparam int SQW      = 2 * SW + 2;
  localparam int LENW     = SW + 1;

  localparam int SQ_XW     = 64;
  localparam int SQ_PER    = 2;
  localparam int SQ_STAGES = SQ_XW / 2 / SQ_PER;
  localparam int SQRT_LAT  = SQ_STAGES + 2;

  localparam int DIV_NW     = 68;
  localparam int DIV_DW     = DW;
  localparam int DIV_QW     = 20;
  localparam int DIV_EW     = DIV_NW + DIV_QW;
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = DIV_QW / DIV_PER;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  localparam int NORM_W  = 16;
  localparam int NQW     = 15;
  localparam int NORM_FRAC = 15;
  localparam int ALB_W   = 20;
  localparam int ALB_FRAC = 16;
  localparam logic [ALB_W-1:0] ALB_MAX = '1;
  localparam logic [DW-1:0] DET_MIN = DW'(16);

  localparam logic [1:0] CFG_LIGHT_ONE   = 2'd0;
  localparam logic [1:0] CFG_LIGHT_TWO   = 2'd1;
  localparam logic [1:0] CFG_LIGHT_THREE = 2'd2;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd3;

  typedef struct packed {
    logic [8:0][AW-1:0] adj;
    logic [DW-1:0]      det_mag;
    logic               det_neg;
    logic               singular;
    logic [IW-1:0]      thresh;
  } cfg_info_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                vis;
    logic                sol;
    logic [2:0]          neg;
    logic [2:0][SW-1:0]  v;
    logic [SHW-1:0]      sh;
  } front_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                vis;
    logic                sol;
    logic [2:0]          neg;
    logic                zero;
    logic                sat;
  } side_t;

endpackage
`default_nettype wire

FILE: design/psps_cfg.sv
// psps_cfg: configuration registers, adjugate and determinant of the light matrix
// depends on psps_pkg
`default_nettype none
module psps_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [psps_pkg::LIGHT_W-1:0] cfg_wdata,
  output psps_pkg::cfg_info_t               info
);

  logic [psps_pkg::LIGHT_W-1:0] light_r [3];
  logic [psps_pkg::IW-1:0]      thresh_r;
  logic [8:0][psps_pkg::AW-1:0] adj_r, adj_nxt;
  logic signed [psps_pkg::DW-1:0] det_r, det_nxt;
  logic signed [psps_pkg::LW-1:0] s [3][3];

  function automatic logic signed [psps_pkg::AW-1:0] cof(
    input logic signed [psps_pkg::LW-1:0] p, q, r, t);
    logic signed [psps_pkg::AW-1:0] pe, qe, re, te;
    pe = psps_pkg::AW'(p);
    qe = psps_pkg::AW'(q);
    re = psps_pkg::AW'(r);
    te = psps_pkg::AW'(t);
    return pe * qe - re * te;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r[0] <= '0;
      light_r[1] <= '0;
      light_r[2] <= '0;
      thresh_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psps_pkg::CFG_LIGHT_ONE:   light_r[0] <= cfg_wdata;
        psps_pkg::CFG_LIGHT_TWO:   light_r[1] <= cfg_wdata;
        psps_pkg::CFG_LIGHT_THREE: light_r[2] <= cfg_wdata;
        psps_pkg::CFG_THRESHOLD:   thresh_r   <= cfg_wdata[psps_pkg::IW-1:0];
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s[r][c] = $signed(light_r[r][psps_pkg::LW*c +: psps_pkg::LW]);
      end
    end
    adj_nxt[0] = cof(s[1][1], s[2][2], s[1][2], s[2][1]);
    adj_nxt[1] = cof(s[0][2], s[2][1], s[0][1], s[2][2]);
    adj_nxt[2] = cof(s[0][1], s[1][2], s[0][2], s[1][1]);
    adj_nxt[3] = cof(s[1][2], s[2][0], s[1][0], s[2][2]);
    adj_nxt[4] = cof(s[0][0], s[2][2], s[0][2], s[2][0]);
    adj_nxt[5] = cof(s[0][2], s[1][0], s[0][0], s[1][2]);
    adj_nxt[6] = cof(s[1][0], s[2][1], s[1][1], s[2][0]);
    adj_nxt[7] = cof(s[0][1], s[2][0], s[0][0], s[2][1]);
    adj_nxt[8] = cof(s[0][0], s[1][1], s[0][1], s[1][0]);
  end

  always_comb begin
    logic signed [psps_pkg::DW-1:0] se, ae;
    det_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      se = psps_pkg::DW'(s[0][c]);
      ae = psps_pkg::DW'($signed(adj_r[c*3]));
      det_nxt = det_nxt + se * ae;
    end
  end

  always_ff @(posedge clk) begin
    adj_r <= adj_nxt;
    det_r <= det_nxt;
  end

  always_comb begin
    info.adj      = adj_r;
    info.det_neg  = det_r[psps_pkg::DW-1];
    info.det_mag  = info.det_neg ? psps_pkg::DW'(-det_r) : psps_pkg::DW'(det_r);
    info.singular = info.det_mag < psps_pkg::DET_MIN;
    info.thresh   = thresh_r;
  end

endmodule
`default_nettype wire

FILE: design/psps_front.sv
// psps_front: visibility test, solution vector n = adj(S) * I, magnitude and
// normalizing shift; four register stages
// depends on psps_pkg
`default_nettype none
module psps_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          take,
  input  wire logic [psps_pkg::ROW_BITS-1:0] row,
  input  wire logic [psps_pkg::COL_BITS-1:0] col,
  input  wire logic [psps_pkg::IW-1:0]       ia,
  input  wire logic [psps_pkg::IW-1:0]       ib,
  input  wire logic [psps_pkg::IW-1:0]       ic,
  input  psps_pkg::cfg_info_t                info,
  output logic                               fo_valid,
  output psps_pkg::front_t                   fo
);

  logic                          v1_r, v2_r, v3_r, v4_r;
  logic [psps_pkg::ROW_BITS-1:0] row1_r, row2_r, row3_r;
  logic [psps_pkg::COL_BITS-1:0] col1_r, col2_r, col3_r;
  logic                          vis1_r, vis2_r, vis3_r;
  logic [2:0][psps_pkg::IW-1:0]  i1_r;
  logic [2:0][psps_pkg::NW-1:0]  n2_r, n2_nxt;
  logic [2:0][psps_pkg::VW-1:0]  m3_r, m3_nxt;
  logic [2:0]                    ng3_r;
  psps_pkg::front_t              fo_r, fo_nxt;

  always_comb begin
    logic signed [psps_pkg::NW-1:0] acc, ae, ie;
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int c = 0; c < 3; c++) begin
        ae  = psps_pkg::NW'($signed(info.adj[r*3+c]));
        ie  = $signed({{(psps_pkg::NW-psps_pkg::IW){1'b0}}, i1_r[c]});
        acc = acc + ae * ie;
      end
      n2_nxt[r] = acc;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      m3_nxt[r] = n2_r[r][psps_pkg::NW-1] ? psps_pkg::VW'(-$signed(n2_r[r]))
                                          : n2_r[r][psps_pkg::VW-1:0];
    end
  end

  always_comb begin
    logic [psps_pkg::VW-1:0] orv, tmp;
    int bl;
    orv = m3_r[0] | m3_r[1] | m3_r[2];
    bl = 0;
    for (int b = 0; b < psps_pkg::VW; b++) begin
      if (orv[b]) bl = b + 1;
    end
    fo_nxt.sh  = (bl > psps_pkg::SW) ? psps_pkg::SHW'(bl - psps_pkg::SW) : '0;
    for (int r = 0; r < 3; r++) begin
      tmp = m3_r[r] >> fo_nxt.sh;
      fo_nxt.v[r] = tmp[psps_pkg::SW-1:0];
    end
    fo_nxt.row = row3_r;
    fo_nxt.col = col3_r;
    fo_nxt.vis = vis3_r;
    fo_nxt.sol = vis3_r && !info.singular;
    fo_nxt.neg = ng3_r ^ {3{info.det_neg}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    row1_r <= row;
    col1_r <= col;
    vis1_r <= (ia > info.thresh) && (ib > info.thresh) && (ic > info.thresh);
    i1_r   <= {ic, ib, ia};
    row2_r <= row1_r;
    col2_r <= col1_r;
    vis2_r <= vis1_r;
    n2_r   <= n2_nxt;
    row3_r <= row2_r;
    col3_r <= col2_r;
    vis3_r <= vis2_r;
    m3_r   <= m3_nxt;
    ng3_r  <= {n2_r[2][psps_pkg::NW-1], n2_r[1][psps_pkg::NW-1], n2_r[0][psps_pkg::NW-1]};
    fo_r   <= fo_nxt;
  end

  assign fo_valid = v4_r;
  assign fo       = fo_r;

endmodule
`default_nettype wire

FILE: design/psps_sqrt.sv
// psps_sqrt: squared length of the shifted vector and its pipelined integer
// square root, two result bits per stage
// depends on psps_pkg
`default_nettype none
module psps_sqrt (
  input  wire logic                             clk,
  input  wire logic [2:0][psps_pkg::SW-1:0]     v,
  output logic [psps_pkg::LENW-1:0]             len
);

  logic [2:0][2*psps_pkg::SW-1:0] sq_r;
  logic [psps_pkg::SQ_XW-1:0] x_r   [psps_pkg::SQ_STAGES+1];
  logic [psps_pkg::SQ_XW-1:0] res_r [psps_pkg::SQ_STAGES+1];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      sq_r[r] <= v[r] * v[r];
    end
    x_r[0]   <= psps_pkg::SQ_XW'(psps_pkg::SQW'(sq_r[0]) + psps_pkg::SQW'(sq_r[1])
                                 + psps_pkg::SQW'(sq_r[2]));
    res_r[0] <= '0;
  end

  for (genvar j = 0; j < psps_pkg::SQ_STAGES; j++) begin : g_stage
    logic [psps_pkg::SQ_XW-1:0] x_nxt, res_nxt;
    always_comb begin
      logic [psps_pkg::SQ_XW-1:0] bv;
      x_nxt   = x_r[j];
      res_nxt = res_r[j];
      for (int i = 0; i < psps_pkg::SQ_PER; i++) begin
        bv = psps_pkg::SQ_XW'(1) << (2 * (psps_pkg::SQ_XW/2 - 1 - psps_pkg::SQ_PER*j - i));
        if (x_nxt >= res_nxt + bv) begin
          x_nxt   = x_nxt - (res_nxt + bv);
          res_nxt = (res_nxt >> 1) + bv;
        end else begin
          res_nxt = res_nxt >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      x_r[j+1]   <= x_nxt;
      res_r[j+1] <= res_nxt;
    end
  end

  assign len = res_r[psps_pkg::SQ_STAGES][psps_pkg::LENW-1:0];

endmodule
`default_nettype wire

FILE: design/psps_div.sv
// psps_div: pipelined restoring divider, two quotient bits per stage;
// the quotient must fit in DIV_QW bits
// depends on psps_pkg
`default_nettype none
module psps_div (
  input  wire logic                         clk,
  input  wire logic [psps_pkg::DIV_NW-1:0]  num,
  input  wire logic [psps_pkg::DIV_DW-1:0]  den,
  output logic [psps_pkg::DIV_QW-1:0]       quo
);

  logic [psps_pkg::DIV_NW-1:0] rem_r [psps_pkg::DIV_STAGES+1];
  logic [psps_pkg::DIV_DW-1:0] d_r   [psps_pkg::DIV_STAGES+1];
  logic [psps_pkg::DIV_QW-1:0] q_r   [psps_pkg::DIV_STAGES+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    d_r[0]   <= den;
    q_r[0]   <= '0;
  end

  for (genvar j = 0; j < psps_pkg::DIV_STAGES; j++) begin : g_stage
    logic [psps_pkg::DIV_NW-1:0] rem_nxt;
    logic [psps_pkg::DIV_QW-1:0] q_nxt;
    always_comb begin
      logic [psps_pkg::DIV_EW-1:0] rx, dx;
      int k;
      rx    = psps_pkg::DIV_EW'(rem_r[j]);
      q_nxt = q_r[j];
      for (int t = 0; t < psps_pkg::DIV_PER; t++) begin
        k  = psps_pkg::DIV_QW - 1 - psps_pkg::DIV_PER*j - t;
        dx = psps_pkg::DIV_EW'(d_r[j]) << k;
        if (rx >= dx) begin
          rx       = rx - dx;
          q_nxt[k] = 1'b1;
        end
      end
      rem_nxt = rx[psps_pkg::DIV_NW-1:0];
    end
    always_ff @(posedge clk) begin
      rem_r[j+1] <= rem_nxt;
      d_r[j+1]   <= d_r[j];
      q_r[j+1]   <= q_nxt;
    end
  end

  assign quo = q_r[psps_pkg::DIV_STAGES];

endmodule
`default_nettype wire

FILE: design/photometric_stereo_pixel_solve.sv
// photometric_stereo_pixel_solve: top level of the three-light pixel solver
// depends on psps_pkg, psps_cfg, psps_front, psps_sqrt, psps_div
//
// One pixel is taken in every clock cycle and busy stays low. Each result
// appears on the out_ ports with out_valid high for one cycle, after the front
// stages, the 16-stage square root (two bits a stage), the dividers that form
// the normal and the albedo and the output register, in the order the pixels
// came in; the receiver cannot stall.
// Light registers must be written at least one cycle before the next start.
`default_nettype none
module photometric_stereo_pixel_solve (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [psps_pkg::ROW_BITS-1:0] in_pixel_row,
  input  wire logic [psps_pkg::COL_BITS-1:0] in_pixel_col,
  input  wire logic [7:0]                    in_intensity_a,
  input  wire logic [7:0]                    in_intensity_b,
  input  wire logic [7:0]                    in_intensity_c,
  output logic                               out_valid,
  output logic [psps_pkg::ROW_BITS-1:0]      out_row,
  output logic [psps_pkg::COL_BITS-1:0]      out_col,
  output logic                               out_visible,
  output logic                               out_solved,
  output logic signed [15:0]                 out_normal_x,
  output logic signed [15:0]                 out_normal_y,
  output logic signed [15:0]                 out_normal_z,
  output logic [19:0]                        out_albedo,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [59:0]                   cfg_wdata
);

  psps_pkg::cfg_info_t info;
  psps_pkg::front_t    fo;
  logic                fo_valid;
  logic [psps_pkg::LENW-1:0] len;

  psps_pkg::front_t d1_r [psps_pkg::SQRT_LAT];
  logic [psps_pkg::SQRT_LAT-1:0] dv1_r;

  psps_pkg::side_t p_r, p_nxt;
  logic            pv_r;
  logic [3:0][psps_pkg::DIV_NW-1:0] num_r, num_nxt;
  logic [3:0][psps_pkg::DIV_DW-1:0] den_r, den_nxt;
  logic [3:0][psps_pkg::DIV_QW-1:0] quo;

  psps_pkg::side_t s2_r [psps_pkg::DIV_LAT];
  logic [psps_pkg::DIV_LAT-1:0] sv2_r;

  logic                                   ov_r;
  logic [psps_pkg::ROW_BITS-1:0]          orow_r;
  logic [psps_pkg::COL_BITS-1:0]          ocol_r;
  logic                                   ovis_r, osol_r;
  logic [2:0][psps_pkg::NORM_W-1:0]       onrm_r, onrm_nxt;
  logic [psps_pkg::ALB_W-1:0]             oalb_r, oalb_nxt;

  assign busy = 1'b0;

  psps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .info      (info)
  );

  psps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (start && !busy),
    .row      (in_pixel_row),
    .col      (in_pixel_col),
    .ia       (in_intensity_a),
    .ib       (in_intensity_b),
    .ic       (in_intensity_c),
    .info     (info),
    .fo_valid (fo_valid),
    .fo       (fo)
  );

  psps_sqrt u_sqrt (
    .clk (clk),
    .v   (fo.v),
    .len (len)
  );

  always_ff @(posedge clk) begin
    d1_r[0] <= fo;
    for (int i = 1; i < psps_pkg::SQRT_LAT; i++) begin
      d1_r[i] <= d1_r[i-1];
    end
  end

  always_comb begin
    psps_pkg::front_t f;
    logic [psps_pkg::DIV_NW-1:0] big;
    f   = d1_r[psps_pkg::SQRT_LAT-1];
    big = psps_pkg::DIV_NW'(len) << f.sh;
    for (int r = 0; r < 3; r++) begin
      num_nxt[r] = (psps_pkg::DIV_NW'(f.v[r]) << psps_pkg::NORM_FRAC)
                   + psps_pkg::DIV_NW'(len);
      den_nxt[r] = psps_pkg::DIV_DW'(len) << 1;
    end
    num_nxt[3] = big << psps_pkg::ALB_FRAC;
    den_nxt[3] = info.det_mag;
    p_nxt.row  = f.row;
    p_nxt.col  = f.col;
    p_nxt.vis  = f.vis;
    p_nxt.sol  = f.sol;
    p_nxt.neg  = f.neg;
    p_nxt.zero = (len == '0);
    p_nxt.sat  = big >= (psps_pkg::DIV_NW'(info.det_mag) << 4);
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    psps_div u_div (
      .clk (clk),
      .num (num_r[g]),
      .den (den_r[g]),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    s2_r[0] <= p_r;
    for (int i = 1; i < psps_pkg::DIV_LAT; i++) begin
      s2_r[i] <= s2_r[i-1];
    end
  end

  always_comb begin
    psps_pkg::side_t s;
    logic [psps_pkg::NORM_W-1:0] qn;
    s = s2_r[psps_pkg::DIV_LAT-1];
    for (int r = 0; r < 3; r++) begin
      qn = {1'b0, quo[r][psps_pkg::NQW-1:0]};
      if (s.sol && !s.zero) begin
        onrm_nxt[r] = s.neg[r] ? psps_pkg::NORM_W'(-qn) : qn;
      end else begin
        onrm_nxt[r] = '0;
      end
    end
    if (s.sol && !s.zero) begin
      oalb_nxt = s.sat ? psps_pkg::ALB_MAX : quo[3];
    end else begin
      oalb_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv1_r <= '0;
      pv_r  <= 1'b0;
      sv2_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      dv1_r <= {dv1_r[psps_pkg::SQRT_LAT-2:0], fo_valid};
      pv_r  <= dv1_r[psps_pkg::SQRT_LAT-1];
      sv2_r <= {sv2_r[psps_pkg::DIV_LAT-2:0], pv_r};
      ov_r  <= sv2_r[psps_pkg::DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    orow_r <= s2_r[psps_pkg::DIV_LAT-1].row;
    ocol_r <= s2_r[psps_pkg::DIV_LAT-1].col;
    ovis_r <= s2_r[psps_pkg::DIV_LAT-1].vis;
    osol_r <= s2_r[psps_pkg::DIV_LAT-1].sol;
    onrm_r <= onrm_nxt;
    oalb_r <= oalb_nxt;
  end

  assign out_valid    = ov_r;
  assign out_row      = orow_r;
  assign out_col      = ocol_r;
  assign out_visible  = ovis_r;
  assign out_solved   = osol_r;
  assign out_normal_x = $signed(onrm_r[0]);
  assign out_normal_y = $signed(onrm_r[1]);
  assign out_normal_z = $signed(onrm_r[2]);
  assign out_albedo   = oalb_r;

endmodule
`default_nettype wire

FILE: tb/photometric_stereo_pixel_solve_checker.sv
// checker for the three-light photometric stereo pixel solver: watches the
// pixel and result ports, predicts each result and compares it
// depends on psps_pkg
`default_nettype none
module photometric_stereo_pixel_solve_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [psps_pkg::ROW_BITS-1:0] in_pixel_row,
  input  wire logic [psps_pkg::COL_BITS-1:0] in_pixel_col,
  input  wire logic [7:0]                    in_intensity_a,
  input  wire logic [7:0]                    in_intensity_b,
  input  wire logic [7:0]                    in_intensity_c,
  input  wire logic                          out_valid,
  input  wire logic [psps_pkg::ROW_BITS-1:0] out_row,
  input  wire logic [psps_pkg::COL_BITS-1:0] out_col,
  input  wire logic                          out_visible,
  input  wire logic                          out_solved,
  input  wire logic [15:0]                   out_normal_x,
  input  wire logic [15:0]                   out_normal_y,
  input  wire logic [15:0]                   out_normal_z,
  input  wire logic [19:0]                   out_albedo,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [59:0]                   cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [psps_pkg::ROW_BITS-1:0] row;
    logic [psps_pkg::COL_BITS-1:0] col;
    logic        vis;
    logic        sol;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [19:0] alb;
  } pixel_result_t;

  logic [59:0] lights [3];
  logic [7:0]  thresh;
  pixel_result_t solve_queue [$];

  function automatic longint field20(logic [59:0] r, int pos);
    logic signed [19:0] f;
    f = r[pos +: 20];
    return longint'(f);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic pixel_result_t solve_pixel(logic [psps_pkg::ROW_BITS-1:0] row,
                                                logic [psps_pkg::COL_BITS-1:0] col,
                                                logic [7:0] ia, logic [7:0] ib,
                                                logic [7:0] ic);
    pixel_result_t p;
    longint s [3][3];
    longint a [3][3];
    longint n [3];
    longint inten [3];
    longint unsigned v [3];
    longint unsigned mx, sum, len, big, ad, q, rem;
    longint det;
    int sh;
    p = '0;
    p.row = row;
    p.col = col;
    p.vis = ia > thresh && ib > thresh && ic > thresh;
    if (!p.vis) return p;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) s[r][c] = field20(lights[r], 20 * c);
    a[0][0] = s[1][1] * s[2][2] - s[1][2] * s[2][1];
    a[0][1] = s[0][2] * s[2][1] - s[0][1] * s[2][2];
    a[0][2] = s[0][1] * s[1][2] - s[0][2] * s[1][1];
    a[1][0] = s[1][2] * s[2][0] - s[1][0] * s[2][2];
    a[1][1] = s[0][0] * s[2][2] - s[0][2] * s[2][0];
    a[1][2] = s[0][2] * s[1][0] - s[0][0] * s[1][2];
    a[2][0] = s[1][0] * s[2][1] - s[1][1] * s[2][0];
    a[2][1] = s[0][1] * s[2][0] - s[0][0] * s[2][1];
    a[2][2] = s[0][0] * s[1][1] - s[0][1] * s[1][0];
    det = s[0][0] * a[0][0] + s[0][1] * a[1][0] + s[0][2] * a[2][0];
    ad = mag(det);
    if (ad < 16) return p;
    p.sol = 1'b1;
    inten[0] = ia;
    inten[1] = ib;
    inten[2] = ic;
    mx = 0;
    for (int r = 0; r < 3; r++) begin
      n[r] = a[r][0] * inten[0] + a[r][1] * inten[1] + a[r][2] * inten[2];
      v[r] = mag(n[r]);
      if (v[r] > mx) mx = v[r];
    end
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    for (int r = 0; r < 3; r++) v[r] >>= sh;
    sum = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    len = root64(sum);
    if (len == 0) return p;
    big = len << sh;
    for (int r = 0; r < 3; r++) begin
      q = ((v[r] << 15) + len) / (len << 1);
      if ((n[r] < 0) != (det < 0)) q = -q;
      if (r == 0) p.nx = q[15:0];
      else if (r == 1) p.ny = q[15:0];
      else p.nz = q[15:0];
    end
    if (big >= (ad << 4)) begin
      p.alb = '1;
    end else begin
      q = big / ad;
      rem = big % ad;
      for (int k = 0; k < 16; k++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= ad) begin
          rem -= ad;
          q |= 1;
        end
      end
      p.alb = q[19:0];
    end
    return p;
  endfunction

  assign pending = solve_queue.size();

  always @(posedge clk) begin
    pixel_result_t want, got;
    if (!rst_n) begin
      lights[0] <= '0;
      lights[1] <= '0;
      lights[2] <= '0;
      thresh <= '0;
      fail_count <= 0;
      solve_queue.delete();
    end else begin
      if (start && !busy)
        solve_queue.insert(solve_queue.size(),
                           solve_pixel(in_pixel_row, in_pixel_col, in_intensity_a,
                                       in_intensity_b, in_intensity_c));
      if (out_valid) begin
        got = '{out_row, out_col, out_visible, out_solved, out_normal_x, out_normal_y,
                out_normal_z, out_albedo};
        if (solve_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = solve_queue.pop_front();
          if (want !== got) begin
            if (fail_count < 10) begin
              $display("mismatch: expected row %0d col %0d vis %b sol %b n %h %h %h alb %h",
                       want.row, want.col, want.vis, want.sol, want.nx, want.ny, want.nz,
                       want.alb);
              $display("          got      row %0d col %0d vis %b sol %b n %h %h %h alb %h",
                       got.row, got.col, got.vis, got.sol, got.nx, got.ny, got.nz,
                       got.alb);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          psps_pkg::CFG_LIGHT_ONE:   lights[0] <= cfg_wdata;
          psps_pkg::CFG_LIGHT_TWO:   lights[1] <= cfg_wdata;
          psps_pkg::CFG_LIGHT_THREE: lights[2] <= cfg_wdata;
          psps_pkg::CFG_THRESHOLD:   thresh <= cfg_wdata[7:0];
        endcase
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb_photometric_stereo_pixel_solve.sv
// testbench top for the three-light photometric stereo pixel solver: drives
// configuration phases and pixel transactions, gives the verdict
// depends on psps_pkg, photometric_stereo_pixel_solve, its checker
`default_nettype none
module tb_photometric_stereo_pixel_solve;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN = 60;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [psps_pkg::ROW_BITS-1:0] in_pixel_row;
  logic [psps_pkg::COL_BITS-1:0] in_pixel_col;
  logic [7:0]  in_intensity_a;
  logic [7:0]  in_intensity_b;
  logic [7:0]  in_intensity_c;
  logic        out_valid;
  logic [psps_pkg::ROW_BITS-1:0] out_row;
  logic [psps_pkg::COL_BITS-1:0] out_col;
  logic        out_visible;
  logic        out_solved;
  logic [15:0] out_normal_x;
  logic [15:0] out_normal_y;
  logic [15:0] out_normal_z;
  logic [19:0] out_albedo;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [59:0] cfg_wdata;
  int          fail_count;
  int          pending;

  photometric_stereo_pixel_solve uut (.*);
  photometric_stereo_pixel_solve_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [59:0] pack_light(int x, int y, int z);
    logic [19:0] fx, fy, fz;
    fx = 20'(x);
    fy = 20'(y);
    fz = 20'(z);
    return {fz, fy, fx};
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [59:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_lights(logic [59:0] l1, logic [59:0] l2, logic [59:0] l3,
                            logic [7:0] th);
    drain_pixels();
    write_reg(psps_pkg::CFG_LIGHT_ONE, l1);
    write_reg(psps_pkg::CFG_LIGHT_TWO, l2);
    write_reg(psps_pkg::CFG_LIGHT_THREE, l3);
    write_reg(psps_pkg::CFG_THRESHOLD, {52'd0, th});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [psps_pkg::ROW_BITS-1:0] r,
                            logic [psps_pkg::COL_BITS-1:0] c, logic [7:0] a,
                            logic [7:0] b, logic [7:0] d, bit gaps);
    int g;
    start <= 1'b1;
    in_pixel_row <= r;
    in_pixel_col <= c;
    in_intensity_a <= a;
    in_intensity_b <= b;
    in_intensity_c <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 50) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) g = 0;
      if (g != 0) begin
        start <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic random_pixel(bit gaps);
    send_pixel(psps_pkg::ROW_BITS'($urandom), psps_pkg::COL_BITS'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom), gaps);
  endtask

  function automatic logic [59:0] rand_light(int kind);
    case (kind)
      0: return 60'({$urandom, $urandom});
      1: return pack_light($urandom_range(0, 512) - 256, $urandom_range(0, 512) - 256,
                           $urandom_range(0, 512) - 256);
      default: return pack_light($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                                 $urandom_range(0, 8) - 4);
    endcase
  endfunction

  initial begin
    start = 1'b0;
    in_pixel_row = '0;
    in_pixel_col = '0;
    in_intensity_a = '0;
    in_intensity_b = '0;
    in_intensity_c = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset lights: singular
    send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 0);
    send_pixel(12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff, 0);
    set_lights(pack_light(256, 0, 0), pack_light(0, 256, 0), pack_light(0, 0, 256), 8'd10);
    send_pixel(12'd1, 12'd2, 8'd200, 8'd100, 8'd50, 0);
    send_pixel(12'd3, 12'd4, 8'd10, 8'd100, 8'd50, 0);
    send_pixel(12'd5, 12'd6, 8'd11, 8'd11, 8'd11, 0);
    send_pixel(12'd7, 12'd8, 8'hff, 8'hff, 8'hff, 0);
    // tiny lights: determinants below and at the singular limit
    set_lights(pack_light(1, 0, 0), pack_light(0, 1, 0), pack_light(0, 0, 1), 8'd0);
    send_pixel(12'd9, 12'd9, 8'hff, 8'h01, 8'h80, 0);
    set_lights(pack_light(4, 0, 0), pack_light(0, 2, 0), pack_light(0, 0, 2), 8'd0);
    send_pixel(12'd10, 12'd10, 8'h01, 8'h01, 8'h01, 0);
    // maximal magnitudes, positive determinant
    set_lights(pack_light(-524288, 524287, 0), pack_light(524287, 524287, 0),
               pack_light(0, 0, -524288), 8'd0);
    send_pixel(12'd11, 12'd11, 8'hff, 8'hff, 8'hff, 0);
    send_pixel(12'd12, 12'd12, 8'h01, 8'hff, 8'h80, 0);
    // equal intensities with singular and with solvable lights
    set_lights(pack_light(256, 0, 0), pack_light(256, 256, 0), pack_light(0, 256, 0) |
               pack_light(0, 0, 0), 8'd0);
    send_pixel(12'd13, 12'd13, 8'd5, 8'd5, 8'd5, 0);
    set_lights(pack_light(256, -256, 0), pack_light(0, 256, -256), pack_light(1, 1, 1), 8'd0);
    send_pixel(12'd14, 12'd14, 8'd7, 8'd7, 8'd7, 0);
    set_lights('1, '1, '1, 8'hff);
    send_pixel(12'd15, 12'd15, 8'hff, 8'hff, 8'hff, 0);

    for (int phase = 0; phase < 15; phase++) begin
      set_lights(rand_light(phase % 3), rand_light(phase % 3), rand_light(phase % 3),
                 (phase % 4 == 0) ? 8'd0 :
                 ((phase % 4 == 1) ? 8'hfe : 8'($urandom_range(0, 60))));
      for (int i = 0; i < 50; i++) random_pixel(1);
    end

    drain_pixels();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
design/psps_pkg.sv
design/psps_cfg.sv
design/psps_front.sv
design/psps_sqrt.sv
design/psps_div.sv
design/photometric_stereo_pixel_solve.sv
tb/photometric_stereo_pixel_solve_checker.sv
tb/tb_photometric_stereo_pixel_solve.sv
